// ----- hw/rtl/cpf_pkg.sv -----
// Package for the complementary pitch filter: widths, limits, register
// indexes and the CORDIC angle table. No dependencies.
package cpf_pkg;

    localparam int CordicStepsDefault = 16;
    localparam int CordicStepsMax     = 24;
    localparam int PitchLimit         = 46080;
    localparam int AccLimit           = 23040;

    localparam logic [1:0] REG_GYRO_OFFSET  = 2'd0;
    localparam logic [1:0] REG_BLEND_WEIGHT = 2'd1;
    localparam logic [1:0] REG_TIME_STEP    = 2'd2;

    typedef struct packed {
        logic signed [19:0] gyro_offset;
        logic        [16:0] blend_weight;
        logic        [15:0] time_step;
    } cpf_cfg_t;

    function automatic logic [21:0] atan_entry(input logic [4:0] i);
        logic [21:0] v;
        case (i)
            5'd0:    v = 22'd2949120;
            5'd1:    v = 22'd1740967;
            5'd2:    v = 22'd919879;
            5'd3:    v = 22'd466945;
            5'd4:    v = 22'd234379;
            5'd5:    v = 22'd117304;
            5'd6:    v = 22'd58666;
            5'd7:    v = 22'd29335;
            5'd8:    v = 22'd14668;
            5'd9:    v = 22'd7334;
            5'd10:   v = 22'd3667;
            5'd11:   v = 22'd1833;
            5'd12:   v = 22'd917;
            5'd13:   v = 22'd458;
            5'd14:   v = 22'd229;
            5'd15:   v = 22'd115;
            5'd16:   v = 22'd57;
            5'd17:   v = 22'd29;
            5'd18:   v = 22'd14;
            5'd19:   v = 22'd7;
            5'd20:   v = 22'd4;
            5'd21:   v = 22'd2;
            5'd22:   v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- hw/rtl/cpf_cfg_regs.sv -----
// Configuration registers of the complementary pitch filter.
// Depends on cpf_pkg.
module cpf_cfg_regs
    import cpf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [19:0] cfg_data,
    output cpf_cfg_t    cfg
);

    cpf_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gyro_offset  <= '0;
            cfg_reg.blend_weight <= 17'd64225;
            cfg_reg.time_step    <= 16'd328;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GYRO_OFFSET:  cfg_reg.gyro_offset  <= cfg_data;
                REG_BLEND_WEIGHT: cfg_reg.blend_weight <= cfg_data[16:0];
                REG_TIME_STEP:    cfg_reg.time_step    <= cfg_data[15:0];
                default:          ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- hw/rtl/cpf_core.sv -----
// Sequencer and shared datapath: rate, square root, CORDIC and blend.
// Depends on cpf_pkg.
module cpf_core
    import cpf_pkg::*;
#(
    parameter int CORDIC_STEPS = CordicStepsDefault
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cpf_cfg_t           cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] gyro_raw,
    input  logic signed [15:0] accel_x_raw,
    input  logic signed [15:0] accel_y_raw,
    input  logic signed [15:0] accel_z_raw,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [16:0] pitch_out,
    output logic signed [15:0] accel_pitch_out
);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_SQ    = 9'b000000010,
        ST_RATE  = 9'b000000100,
        ST_DELTA = 9'b000001000,
        ST_SQRT  = 9'b000010000,
        ST_CORD  = 9'b000100000,
        ST_BLEND = 9'b001000000,
        ST_SUM   = 9'b010000000,
        ST_OUT   = 9'b100000000
    } state_t;

    localparam int StepW = $clog2(CordicStepsMax + 1);

    state_t state_reg, state_next;
    logic [StepW-1:0] cnt_reg;
    logic signed [15:0] g_reg, ax_reg, ay_reg, az_reg;
    logic [31:0] sq_reg;
    logic [31:0] root_reg;
    logic signed [21:0] rate_reg;
    logic signed [21:0] gp_reg;
    logic signed [26:0] cx_reg, cy_reg;
    logic signed [26:0] cz_reg;
    logic signed [15:0] acc_reg;
    logic signed [40:0] prod_reg;
    logic signed [16:0] pitch_reg;
    logic [1:0] phase_reg;

    // shared multiplier: signed 24 x 18
    logic signed [23:0] ma;
    logic signed [17:0] mb;
    logic signed [41:0] mp;
    assign mp = ma * mb;

    logic [16:0] alpha;
    assign alpha = (cfg.blend_weight > 17'd65536) ? 17'd65536 : cfg.blend_weight;

    logic [21:0] rc_mag;
    logic signed [22:0] rc;
    assign rc = 23'(rate_reg) - 23'(cfg.gyro_offset);
    assign rc_mag = rc[22] ? 22'(-rc) : 22'(rc);

    logic signed [21:0] dmag;
    assign dmag = 22'((mp + 42'sd32768) >>> 16);

    logic [26:0] sx, sy;
    assign sx = 27'(cx_reg >>> cnt_reg);
    assign sy = 27'(cy_reg >>> cnt_reg);

    always_comb
    begin
        ma = '0;
        mb = '0;
        unique case (state_reg)
            ST_SQ:    begin ma = 24'(ax_reg); mb = 18'(phase_reg[0] ? az_reg : ax_reg); end
            ST_RATE:  begin ma = 24'(g_reg); mb = 18'sd640; end
            ST_DELTA: begin ma = 24'(rc_mag); mb = $signed({2'b00, cfg.time_step}); end
            ST_BLEND: begin ma = 24'(gp_reg); mb = $signed({1'b0, alpha}); end
            ST_SUM:   begin ma = 24'(acc_reg); mb = $signed(18'(18'd65536 - alpha)); end
            default:  ;
        endcase
        if (state_reg == ST_SQ && phase_reg[0])
            ma = 24'(az_reg);
    end

    // rate divide by 41 by reciprocal: q = (m * ceil(2^31 / 41)) >> 31, exact here
    logic [24:0] nm;
    logic [50:0] qp;
    logic [21:0] q0;
    always_comb
    begin
        nm = prod_reg[40] ? 25'(-prod_reg) : 25'(prod_reg);
        qp = 51'(nm + 25'd20) * 51'd52377650;
        q0 = 22'(qp >> 31);
    end

    logic signed [47:0] accsum_reg;
    logic signed [47:0] fin;
    logic [26:0] zm;
    logic signed [16:0] ang;

    always_comb
    begin
        zm = cz_reg[26] ? 27'(-cz_reg) : 27'(cz_reg);
        zm = (zm + 27'd128) >> 8;
        if (zm > 27'(AccLimit))
            ang = 17'(AccLimit);
        else
            ang = 17'(zm);
        if (cz_reg[26])
            ang = -ang;
        if (ay_reg == 16'sd0)
            ang = '0;
        fin = (accsum_reg + 48'(mp) + 48'sd32768) >>> 16;
    end

    assign in_ready  = state_reg == ST_IDLE;
    assign out_valid = state_reg == ST_OUT;
    assign pitch_out = pitch_reg;
    assign accel_pitch_out = acc_reg;

    // isqrt uses the classic remainder / root formulation
    logic [31:0] sq_next_rem;
    logic [31:0] root_next;
    logic [31:0] bit_val;
    logic [32:0] trial_sum;
    always_comb
    begin
        bit_val = 32'd1 << (5'(2 * (15 - 32'(cnt_reg))));
        trial_sum = 33'(root_reg) + 33'(bit_val);
        if (33'(sq_reg) >= trial_sum)
        begin
            sq_next_rem = 32'(33'(sq_reg) - trial_sum);
            root_next = (root_reg >> 1) + bit_val;
        end
        else
        begin
            sq_next_rem = sq_reg;
            root_next = root_reg >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            phase_reg <= '0;
            pitch_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        g_reg <= gyro_raw;
                        ax_reg <= accel_x_raw;
                        ay_reg <= accel_y_raw;
                        az_reg <= accel_z_raw;
                        phase_reg <= '0;
                        sq_reg <= '0;
                    end
                end
                ST_SQ:
                begin
                    sq_reg <= sq_reg + 32'(mp);
                    phase_reg <= phase_reg + 2'd1;
                    root_reg <= '0;
                    cnt_reg <= '0;
                end
                ST_RATE:
                    prod_reg <= 41'(mp);
                ST_DELTA:
                begin
                    rate_reg <= prod_reg[40] ? -22'(q0) : 22'(q0);
                    phase_reg <= phase_reg + 2'd1;
                    if (phase_reg == 2'd3)
                    begin
                        gp_reg <= 22'(pitch_reg) + (rc[22] ? -dmag : dmag);
                        cnt_reg <= '0;
                    end
                end
                ST_SQRT:
                begin
                    sq_reg <= sq_next_rem;
                    root_reg <= root_next;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == StepW'(15))
                    begin
                        cx_reg <= 27'({root_next[16:0], 8'd0});
                        cy_reg <= 27'(ay_reg) <<< 8;
                        cz_reg <= '0;
                        cnt_reg <= '0;
                    end
                end
                ST_CORD:
                begin
                    if (!cy_reg[26])
                    begin
                        cx_reg <= cx_reg + $signed(sy);
                        cy_reg <= cy_reg - $signed(sx);
                        cz_reg <= cz_reg + $signed({5'd0, atan_entry(5'(cnt_reg))});
                    end
                    else
                    begin
                        cx_reg <= cx_reg - $signed(sy);
                        cy_reg <= cy_reg + $signed(sx);
                        cz_reg <= cz_reg - $signed({5'd0, atan_entry(5'(cnt_reg))});
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                end
                ST_BLEND:
                begin
                    acc_reg <= 16'(ang);
                    accsum_reg <= 48'(mp);
                end
                ST_SUM:
                begin
                    if (fin > 48'sd46080)
                        pitch_reg <= 17'sd46080;
                    else if (fin < -48'sd46080)
                        pitch_reg <= -17'sd46080;
                    else
                        pitch_reg <= 17'(fin);
                end
                ST_OUT: ;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_valid) state_next = ST_SQ;
            ST_SQ:    if (phase_reg[0]) state_next = ST_RATE;
            ST_RATE:  state_next = ST_DELTA;
            ST_DELTA: if (phase_reg == 2'd3) state_next = ST_SQRT;
            ST_SQRT:  if (cnt_reg == StepW'(15)) state_next = ST_CORD;
            ST_CORD:  if (cnt_reg == StepW'(CORDIC_STEPS - 1)) state_next = ST_BLEND;
            ST_BLEND: state_next = ST_SUM;
            ST_SUM:   state_next = ST_OUT;
            ST_OUT:   if (out_ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid) else $error("ready while result pending");
    a_pitch_lim: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pitch_reg <= 17'sd46080 && pitch_reg >= -17'sd46080))
        else $error("pitch out of range");
    a_acc_lim: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (acc_reg <= 16'sd23040 && acc_reg >= -16'sd23040))
        else $error("accel pitch out of range");
`endif

endmodule

// ----- hw/rtl/complementary_pitch_filter.sv -----
// Complementary pitch filter top level.
// An accepted item passes the square, rate, delta, square root, CORDIC, blend and
// sum states before its result is valid. No new item is accepted until that result
// is taken; the multiplier, square root and CORDIC under one sequencer set this.
// Reset (rst_n, asynchronous, active low) clears the pitch estimate and
// loads the register defaults.
module complementary_pitch_filter
    import cpf_pkg::*;
#(
    parameter int CORDIC_STEPS = CordicStepsDefault
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [19:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // gyro_raw[15:0], accel_x_raw[31:16], accel_y_raw[47:32], accel_z_raw[63:48]
    input  logic [63:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // pitch_out[16:0], accel_pitch_out[32:17], zeros above
    output logic [39:0] m_axis_tdata
);

    cpf_cfg_t cfg;
    logic signed [16:0] pitch;
    logic signed [15:0] accp;

    cpf_cfg_regs u_regs (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .cfg(cfg)
    );

    cpf_core #(.CORDIC_STEPS(CORDIC_STEPS)) u_core (
        .clk(clk), .rst_n(rst_n), .cfg(cfg),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .gyro_raw(s_axis_tdata[15:0]), .accel_x_raw(s_axis_tdata[31:16]),
        .accel_y_raw(s_axis_tdata[47:32]), .accel_z_raw(s_axis_tdata[63:48]),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .pitch_out(pitch), .accel_pitch_out(accp)
    );

    assign m_axis_tdata = {7'd0, accp, pitch};

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the complementary pitch filter.
// Depends on cpf_pkg and complementary_pitch_filter; predicts each result in place.
module testbench;
    import cpf_pkg::*;

    localparam int Steps = 16;
    localparam int CycleLimit = 1500000;
    localparam int HoldCycles = 400;
    localparam logic [1:0] RegUnused = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = REG_GYRO_OFFSET;
    logic [19:0] cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;

    logic [63:0] pending_items[$];
    logic [32:0] expected_results[$];
    logic [63:0] sent_items[$];

    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  hold_req = 1'b0;
    int  hold_cycles = 0;
    logic hold_off;
    bit  hold_sender = 1'b0;
    int  mismatches = 0;
    int  cycles = 0;
    int  sent_count = 0;
    int  recv_count = 0;

    // Predictor state and configuration.
    logic signed [19:0] offset_q;
    logic        [16:0] weight_q;
    logic        [15:0] step_q;
    logic signed [16:0] pitch_q;

    assign hold_off = hold_req && (hold_cycles < HoldCycles);

    complementary_pitch_filter #(.CORDIC_STEPS(Steps)) u_dut (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic longint div_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint int_sqrt(longint n);
        longint r, b;
        r = 0;
        b = 64'sd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint accel_angle(longint ax, longint ay, longint az);
        longint x, y, z, xs, ys, m, a;
        z = 0;
        if (ay == 0)
            return 0;
        x = int_sqrt(ax * ax + az * az) * 256;
        y = ay * 256;
        for (int i = 0; i < Steps && i < 24; i++)
        begin
            xs = div_floor(x, i);
            ys = div_floor(y, i);
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + longint'(atan_entry(5'(i)));
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - longint'(atan_entry(5'(i)));
            end
        end
        m = ((z < 0 ? -z : z) + 128) >> 8;
        a = z < 0 ? -m : m;
        if (a > AccLimit)
            a = AccLimit;
        if (a < -AccLimit)
            a = -AccLimit;
        return a;
    endfunction

    function automatic logic [32:0] predict_pitch(logic [63:0] d);
        longint g, num, rate, rc, m, delta, acc, alpha, p;
        g = longint'($signed(d[15:0]));
        num = g * 640;
        m = ((num < 0 ? -num : num) + 20) / 41;
        rate = num < 0 ? -m : m;
        rc = rate - longint'(offset_q);
        m = ((rc < 0 ? -rc : rc) * longint'(step_q) + 32768) >> 16;
        delta = rc < 0 ? -m : m;
        acc = accel_angle(longint'($signed(d[31:16])), longint'($signed(d[47:32])),
                          longint'($signed(d[63:48])));
        alpha = weight_q > 17'd65536 ? 65536 : longint'(weight_q);
        p = div_floor(alpha * (longint'(pitch_q) + delta) + (65536 - alpha) * acc
                      + 32768, 16);
        if (p > PitchLimit)
            p = PitchLimit;
        if (p < -PitchLimit)
            p = -PitchLimit;
        pitch_q = 17'(p);
        return {16'(acc), 17'(p)};
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Receiver hold-off length, counted while the hold is requested.
    always @(posedge clk)
    begin
        if (hold_req && hold_cycles < HoldCycles)
            hold_cycles <= hold_cycles + 1;
    end

    // Driver.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                sent_items.push_back(s_axis_tdata);
                sent_count <= sent_count + 1;
            end
            if ((!s_axis_tvalid || s_axis_tready) && pending_items.size() > 0
                && !hold_sender && $urandom_range(99) >= send_idle_pct)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= pending_items.pop_front();
            end
            else if (s_axis_tready)
                s_axis_tvalid <= 1'b0;
            m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Prediction in accept order, kept here so config writes between phases apply.
    always @(posedge clk)
    begin
        while (sent_items.size() > 0)
            expected_results.push_back(predict_pitch(sent_items.pop_front()));
    end

    // Monitor.
    always @(posedge clk)
    begin
        logic [32:0] want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            recv_count <= recv_count + 1;
            if (expected_results.size() == 0)
            begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected result %h", m_axis_tdata);
            end
            else
            begin
                want = expected_results.pop_front();
                if (m_axis_tdata[16:0] !== want[16:0]
                    || m_axis_tdata[32:17] !== want[32:17]
                    || m_axis_tdata[39:33] !== 7'd0)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("mismatch: pitch exp %0d got %0d, accel exp %0d got %0d",
                                 $signed(want[16:0]), $signed(m_axis_tdata[16:0]),
                                 $signed(want[32:17]), $signed(m_axis_tdata[32:17]));
                end
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [19:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_GYRO_OFFSET:  offset_q = val;
            REG_BLEND_WEIGHT: weight_q = val[16:0];
            REG_TIME_STEP:    step_q = val[15:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        wait (pending_items.size() == 0);
        @(posedge clk);
        while (sent_count != recv_count || s_axis_tvalid)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    function automatic logic [15:0] rand_field();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom_range(40)) - 16'd20;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic add_random(int n);
        logic [15:0] ay;
        for (int i = 0; i < n; i++)
        begin
            ay = ($urandom_range(15) == 0) ? 16'd0 : rand_field();
            pending_items.push_back({rand_field(), ay, rand_field(), rand_field()});
        end
    endtask

    initial
    begin
        offset_q = '0;
        weight_q = 17'd64225;
        step_q = 16'd328;
        pitch_q = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed items: field extremes, level and all-zero accelerometer.
        pending_items.push_back(64'd0);
        pending_items.push_back({16'h0100, 16'h0000, 16'h0000, 16'h7fff});
        pending_items.push_back({16'h8000, 16'h7fff, 16'h8000, 16'h8000});
        pending_items.push_back({16'h7fff, 16'h8000, 16'h7fff, 16'h7fff});
        pending_items.push_back({16'h0000, 16'h0001, 16'h0000, 16'hffff});
        pending_items.push_back({16'h0000, 16'hffff, 16'h0000, 16'h0001});
        pending_items.push_back({16'h4000, 16'h4000, 16'h4000, 16'h0029});
        pending_items.push_back({16'hffff, 16'hffff, 16'hffff, 16'hffd7});
        pending_items.push_back({16'h0000, 16'h1234, 16'h0000, 16'h0000});
        drain();

        // Pressure: long receiver hold-off while the sender keeps offering.
        hold_req = 1'b1;
        add_random(20);
        wait (hold_cycles == HoldCycles);
        drain();

        write_reg(REG_GYRO_OFFSET, 20'h7ffff);
        write_reg(REG_BLEND_WEIGHT, 20'd65536);
        write_reg(REG_TIME_STEP, 20'hffff);
        write_reg(RegUnused, 20'hfffff);
        add_random(200);
        drain();

        write_reg(REG_GYRO_OFFSET, 20'h80000);
        write_reg(REG_BLEND_WEIGHT, 20'h1ffff);
        write_reg(REG_TIME_STEP, 20'd0);
        send_idle_pct = 74;
        add_random(300);
        drain();

        write_reg(REG_GYRO_OFFSET, 20'(-512000));
        write_reg(REG_BLEND_WEIGHT, 20'd0);
        write_reg(REG_TIME_STEP, 20'd1);
        send_idle_pct = 0;
        recv_stall_pct = 74;
        add_random(300);
        drain();

        write_reg(REG_GYRO_OFFSET, 20'd512000);
        write_reg(REG_BLEND_WEIGHT, 20'd32768);
        write_reg(REG_TIME_STEP, 20'd3000);
        send_idle_pct = 21;
        recv_stall_pct = 21;
        add_random(300);
        drain();

        write_reg(REG_GYRO_OFFSET, 20'd0);
        write_reg(REG_BLEND_WEIGHT, 20'd64225);
        write_reg(REG_TIME_STEP, 20'd328);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        add_random(300);
        wait (pending_items.size() == 0);
        hold_sender = 1'b1;
        drain();
        hold_sender = 1'b0;
        add_random(160);
        drain();
        add_random(160);
        drain();

        if (mismatches == 0 && expected_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
